[sv/tslk_pkg.sv]
`default_nettype none

package tslk_pkg;

    localparam int unsigned FRAME_BYTES = 11;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
    localparam int unsigned IDX_W       = 4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_TICKS    = CFG_IDX_W'(1);

    localparam logic [7:0] RESTART_TICKS_RST = 8'd20;
    localparam logic [7:0] LOSS_TICKS_RST    = 8'd200;

    localparam logic [2:0] MODE_WADDR = 3'd0;
    localparam logic [2:0] MODE_DATA  = 3'd1;
    localparam logic [2:0] MODE_RADDR = 3'd2;
    localparam logic [2:0] MODE_REQ   = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_WADDR = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_RADDR = 3'd3;
    localparam logic [2:0] OP_REQ   = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
        logic [2:0] key_state;
    } evt_t;

    typedef struct packed {
        logic [7:0]       tx_byte;
        logic             frame_good;
        logic [IDX_W-1:0] payload_index;
        logic [7:0]       payload_byte;
        logic             last;
        logic             link_lost;
        logic             bus_restart;
    } res_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] rx_byte;
        logic [2:0] key_state;
    } cmd_t;

    // fixed payload bytes at indices 2 to 6
    function automatic logic [7:0] fixed_byte(input int unsigned i);
        logic [7:0] v;
        v = 8'd0;
        case (i)
            6: v = 8'd3;
            5: v = 8'd4;
            4: v = 8'd15;
            3: v = 8'd16;
            2: v = 8'd17;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] fixed_sum();
        logic [7:0] s;
        s = 8'd0;
        for (int unsigned i = 2; i < 7; i++)
        begin
            if (i < FRAME_BYTES)
            begin
                s = s + fixed_byte(i);
            end
        end
        return s;
    endfunction

    localparam logic [7:0] FIXED_SUM = fixed_sum();

    // refreshed outgoing byte at index i
    function automatic logic [7:0] refresh_byte(input int unsigned i,
                                                input logic [7:0] count,
                                                input logic [2:0] keys);
        logic [7:0] v;
        v = 8'd0;
        if (i == 0)
        begin
            v = FIXED_SUM + {5'd0, keys} + ((FRAME_BYTES > 7) ? count : 8'd0);
        end
        else if (i == 1)
        begin
            v = {5'd0, keys};
        end
        else if (i == 7)
        begin
            v = count;
        end
        else if (i < 7)
        begin
            v = fixed_byte(i);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/tslk_front.sv]
`default_nettype none

module tslk_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    output logic               evt_ready,
    input  wire tslk_pkg::evt_t evt,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output tslk_pkg::cmd_t     cmd
);
    import tslk_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign evt_ready = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.rx_byte   = evt.rx_byte;
        cmd_next.key_state = evt.key_state;
        unique case (evt.mode)
            MODE_WADDR: cmd_next.op = OP_WADDR;
            MODE_DATA:  cmd_next.op = OP_DATA;
            MODE_RADDR: cmd_next.op = OP_RADDR;
            MODE_REQ:   cmd_next.op = OP_REQ;
            MODE_TICK:  cmd_next.op = OP_TICK;
            default:    cmd_next.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (evt_valid && evt_ready)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

[sv/tslk_queue.sv]
`default_nettype none

module tslk_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire tslk_pkg::cmd_t push_word,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output tslk_pkg::cmd_t     pop_word
);
    import tslk_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

[sv/tslk_back.sv]
`default_nettype none

module tslk_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire tslk_pkg::cmd_t                cmd,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output tslk_pkg::res_t                     res,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tslk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import tslk_pkg::*;

    logic [7:0]       rx_buf_reg [FRAME_BYTES];
    logic [7:0]       rx_buf_next [FRAME_BYTES];
    logic [POS_W-1:0] rx_pos_reg, rx_pos_next;
    logic [7:0]       rx_sum_reg, rx_sum_next;
    logic [7:0]       tx_buf_reg [FRAME_BYTES];
    logic [7:0]       tx_buf_next [FRAME_BYTES];
    logic [POS_W-1:0] tx_pos_reg, tx_pos_next;
    logic             reload_reg, reload_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       restart_timer_reg, restart_timer_next;
    logic [7:0]       loss_timer_reg, loss_timer_next;
    logic             lost_reg, lost_next;
    logic [7:0]       restart_ticks_reg;
    logic [7:0]       loss_ticks_reg;
    logic             burst_reg, burst_next;
    logic [POS_W-1:0] burst_idx_reg, burst_idx_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic             out_load;
    logic [7:0]       rt_dec;

    assign out_load  = !out_valid_reg || res_ready;
    assign cmd_ready = out_load && !burst_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rx_buf_next        = rx_buf_reg;
        rx_pos_next        = rx_pos_reg;
        rx_sum_next        = rx_sum_reg;
        tx_buf_next        = tx_buf_reg;
        tx_pos_next        = tx_pos_reg;
        reload_next        = reload_reg;
        count_next         = count_reg;
        restart_timer_next = restart_timer_reg;
        loss_timer_next    = loss_timer_reg;
        lost_next          = lost_reg;
        burst_next         = burst_reg;
        burst_idx_next     = burst_idx_reg;
        out_valid_next     = out_valid_reg;
        out_next           = out_reg;
        rt_dec             = restart_timer_reg;

        if (out_load)
        begin
            out_valid_next = 1'b0;
        end

        if (burst_reg && out_load)
        begin
            // committed payload, one byte per word
            out_valid_next         = 1'b1;
            out_next               = '0;
            out_next.frame_good    = 1'b1;
            out_next.payload_index = IDX_W'(burst_idx_reg);
            out_next.payload_byte  = rx_buf_reg[burst_idx_reg];
            out_next.link_lost     = lost_reg;
            out_next.last          = burst_idx_reg == POS_W'(FRAME_BYTES - 1);
            burst_idx_next         = burst_idx_reg + POS_W'(1);
            if (out_next.last)
            begin
                burst_next = 1'b0;
            end
        end
        else if (cmd_valid && cmd_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            out_next.last  = 1'b1;
            unique case (cmd.op)
                OP_WADDR:
                begin
                    count_next  = count_reg + 8'd1;
                    rx_pos_next = POS_W'(FRAME_BYTES - 1);
                end
                OP_DATA:
                begin
                    count_next = count_reg + 8'd1;
                    rx_buf_next[rx_pos_reg] = cmd.rx_byte;
                    if (rx_pos_reg != '0)
                    begin
                        rx_pos_next = rx_pos_reg - POS_W'(1);
                        rx_sum_next = rx_sum_reg - rx_buf_reg[rx_pos_reg] + cmd.rx_byte;
                    end
                    else if (rx_sum_reg == cmd.rx_byte)
                    begin
                        restart_timer_next     = restart_ticks_reg;
                        loss_timer_next        = loss_ticks_reg;
                        out_next.frame_good    = 1'b1;
                        out_next.payload_index = IDX_W'(1);
                        out_next.payload_byte  = rx_buf_reg[1];
                        out_next.last          = FRAME_BYTES == 2;
                        burst_next             = FRAME_BYTES != 2;
                        burst_idx_next         = POS_W'(2);
                    end
                end
                OP_RADDR:
                begin
                    count_next  = count_reg + 8'd1;
                    tx_pos_next = POS_W'(FRAME_BYTES - 1);
                    reload_next = 1'b0;
                    if (reload_reg)
                    begin
                        for (int unsigned i = 0; i < FRAME_BYTES; i++)
                        begin
                            tx_buf_next[i] = refresh_byte(i, count_reg, cmd.key_state);
                        end
                        out_next.tx_byte = refresh_byte(FRAME_BYTES - 1, count_reg,
                                                        cmd.key_state);
                    end
                    else
                    begin
                        out_next.tx_byte = tx_buf_reg[FRAME_BYTES-1];
                    end
                end
                OP_REQ:
                begin
                    count_next = count_reg + 8'd1;
                    if (tx_pos_reg != '0)
                    begin
                        tx_pos_next = tx_pos_reg - POS_W'(1);
                    end
                    else
                    begin
                        reload_next = 1'b1;
                    end
                    out_next.tx_byte = tx_buf_reg[tx_pos_next];
                end
                OP_TICK:
                begin
                    if (restart_timer_reg != 8'd0)
                    begin
                        rt_dec = restart_timer_reg - 8'd1;
                    end
                    if (rt_dec == 8'd0)
                    begin
                        restart_timer_next   = restart_ticks_reg;
                        out_next.bus_restart = 1'b1;
                    end
                    else
                    begin
                        restart_timer_next = rt_dec;
                    end
                    if (loss_timer_reg != 8'd0)
                    begin
                        loss_timer_next = loss_timer_reg - 8'd1;
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            out_next.link_lost = lost_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int unsigned i = 0; i < FRAME_BYTES; i++)
            begin
                rx_buf_reg[i] <= 8'd0;
                tx_buf_reg[i] <= 8'd0;
            end
            rx_pos_reg        <= '0;
            rx_sum_reg        <= 8'd0;
            tx_pos_reg        <= '0;
            reload_reg        <= 1'b0;
            count_reg         <= 8'd0;
            restart_timer_reg <= RESTART_TICKS_RST;
            loss_timer_reg    <= LOSS_TICKS_RST;
            lost_reg          <= 1'b0;
            restart_ticks_reg <= RESTART_TICKS_RST;
            loss_ticks_reg    <= LOSS_TICKS_RST;
            burst_reg         <= 1'b0;
            burst_idx_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            rx_buf_reg        <= rx_buf_next;
            tx_buf_reg        <= tx_buf_next;
            rx_pos_reg        <= rx_pos_next;
            rx_sum_reg        <= rx_sum_next;
            tx_pos_reg        <= tx_pos_next;
            reload_reg        <= reload_next;
            count_reg         <= count_next;
            restart_timer_reg <= restart_timer_next;
            loss_timer_reg    <= loss_timer_next;
            lost_reg          <= lost_next;
            burst_reg         <= burst_next;
            burst_idx_reg     <= burst_idx_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RESTART_TICKS)
                begin
                    restart_ticks_reg <= cfg_data;
                end
                else if (cfg_index == REG_LOSS_TICKS)
                begin
                    loss_ticks_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

[sv/twi_slave_checksum_frame_link.sv]
`default_nettype none

// Two-wire slave frame engine. Bus events and ticks enter as words on
// the evt channel, pass a one-word classify register and a four-word queue,
// and are carried out by the back end, which owns the frame buffers, the
// link timers and the output register. The back end retires one event per
// cycle while its output is not stalled, except a received frame that passes
// its checksum, which holds it while the payload goes out as ten result
// words, one per cycle through the output register when not stalled. The
// first result word of an event passes the classify register, the queue and
// the output register, in that order. Configuration words are always taken;
// the timers pick up a new reload value at their next reload.
module twi_slave_checksum_frame_link (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          evt_valid,
    output logic                               evt_ready,
    input  wire tslk_pkg::evt_t                evt,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output tslk_pkg::res_t                     res,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tslk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import tslk_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    tslk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tslk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_word   (queue_cmd)
    );

    tslk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

[sv/tslk_checker.sv]
`default_nettype none

module tslk_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           res_valid,
    input  wire logic           res_ready,
    input  wire tslk_pkg::res_t res
);
    import tslk_pkg::*;

    logic             lost_seen_reg;
    logic             burst_open_reg;
    logic [IDX_W-1:0] prev_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_seen_reg  <= 1'b0;
            burst_open_reg <= 1'b0;
            prev_idx_reg   <= '0;
        end
        else if (res_valid && res_ready)
        begin
            lost_seen_reg  <= lost_seen_reg || res.link_lost;
            burst_open_reg <= res.frame_good && !res.last;
            prev_idx_reg   <= res.payload_index;
        end
    end

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

    // link loss is sticky across result words
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && lost_seen_reg |-> res.link_lost)
    else $error("link_lost cleared after being set");

    // burst words follow each other with ascending index
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && burst_open_reg |->
            res.frame_good && res.payload_index == prev_idx_reg + IDX_W'(1))
    else $error("payload burst broken");

    // bus restart only on a single tick word
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.bus_restart |-> !res.frame_good && res.last && !burst_open_reg)
    else $error("bus_restart inside a payload burst");

endmodule

bind twi_slave_checksum_frame_link tslk_checker u_tslk_checker (.*);

`default_nettype wire
